// ----- src/vce_pkg.sv -----
// ============================================================================
// vce_pkg: shared types, constants and microcode for the vertex chain energy core
// Holds datapath widths, controller/datapath command structs and the step table.
// ============================================================================
`default_nettype none

package vce_pkg;

    // Field widths
    localparam int COORD_W  = 16;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int TENS_W   = 16;
    localparam int AREA_W   = 32;
    localparam int ENERGY_W = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Datapath widths
    localparam int RAD_W    = 50;
    localparam int ROOT_W   = RAD_W / 2;
    localparam int REM_W    = ROOT_W + 3;
    localparam int OPND_W   = 25;
    localparam int PROD_W   = 2 * OPND_W;
    localparam int ACC_W    = 90;
    localparam int MAG_W    = 36;
    localparam int HALF_W   = MAG_W / 2;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int CHUNK_W  = SQ_W / 3;
    localparam int ESUM3_W  = 36;
    localparam int STEP_W   = 6;
    localparam int LAST_STEP = 35;

    localparam logic [ENERGY_W-1:0] MAX_ENERGY = {ENERGY_W{1'b1}};

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_APICAL_TENSION  = 3'd0,
        REG_BASAL_TENSION   = 3'd1,
        REG_LATERAL_TENSION = 3'd2,
        REG_AREA_STIFFNESS  = 3'd3,
        REG_TARGET_AREA     = 3'd4
    } cfg_reg_t;

    // Datapath operations (non-multiply)
    typedef enum logic [2:0] {
        OP_NOP,
        OP_ROOT,
        OP_EADD,
        OP_TGT,
        OP_ABS,
        OP_SQSAVE,
        OP_AADD,
        OP_LOADPREV
    } dp_op_t;

    // Emit is separate to keep the op field small
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_DXDX,
        MUL_DYDY,
        MUL_TROOT,
        MUL_UXVY,
        MUL_UYVX,
        MUL_LL,
        MUL_HL,
        MUL_HH,
        MUL_S0,
        MUL_S1,
        MUL_S2
    } mul_sel_t;

    typedef enum logic [1:0] {
        EDGE_APICAL,
        EDGE_BASAL,
        EDGE_LATERAL
    } edge_sel_t;

    typedef struct packed {
        dp_op_t    op;
        mul_sel_t  mul;
        edge_sel_t edge_sel;
        logic      emit;
    } cmd_t;

    typedef struct packed {
        logic root_done;
        logic have_prev;
        logic last;
        logic out_busy;
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RUN,
        S_ROOT,
        S_FIN,
        S_EMIT
    } state_t;

    function automatic cmd_t mk(input dp_op_t op, input mul_sel_t mul, input edge_sel_t e);
        cmd_t c;
        c.op       = op;
        c.mul      = mul;
        c.edge_sel = e;
        c.emit     = 1'b0;
        return c;
    endfunction

    // Step table: the apical, basal and lateral edge terms, then the area term
    function automatic cmd_t ucode(input logic [STEP_W-1:0] step);
        cmd_t c;
        c = mk(OP_NOP, MUL_NONE, EDGE_APICAL);
        unique case (step)
            6'd0:  c = mk(OP_NOP,    MUL_DXDX,  EDGE_APICAL);
            6'd1:  c = mk(OP_NOP,    MUL_DYDY,  EDGE_APICAL);
            6'd3:  c = mk(OP_ROOT,   MUL_NONE,  EDGE_APICAL);
            6'd4:  c = mk(OP_NOP,    MUL_TROOT, EDGE_APICAL);
            6'd6:  c = mk(OP_EADD,   MUL_NONE,  EDGE_APICAL);
            6'd7:  c = mk(OP_NOP,    MUL_DXDX,  EDGE_BASAL);
            6'd8:  c = mk(OP_NOP,    MUL_DYDY,  EDGE_BASAL);
            6'd10: c = mk(OP_ROOT,   MUL_NONE,  EDGE_BASAL);
            6'd11: c = mk(OP_NOP,    MUL_TROOT, EDGE_BASAL);
            6'd13: c = mk(OP_EADD,   MUL_NONE,  EDGE_BASAL);
            6'd14: c = mk(OP_NOP,    MUL_DXDX,  EDGE_LATERAL);
            6'd15: c = mk(OP_NOP,    MUL_DYDY,  EDGE_LATERAL);
            6'd17: c = mk(OP_ROOT,   MUL_NONE,  EDGE_LATERAL);
            6'd18: c = mk(OP_NOP,    MUL_TROOT, EDGE_LATERAL);
            6'd20: c = mk(OP_EADD,   MUL_NONE,  EDGE_LATERAL);
            6'd21: c = mk(OP_NOP,    MUL_UXVY,  EDGE_APICAL);
            6'd22: c = mk(OP_NOP,    MUL_UYVX,  EDGE_APICAL);
            6'd24: c = mk(OP_TGT,    MUL_NONE,  EDGE_APICAL);
            6'd25: c = mk(OP_ABS,    MUL_NONE,  EDGE_APICAL);
            6'd26: c = mk(OP_NOP,    MUL_LL,    EDGE_APICAL);
            6'd27: c = mk(OP_NOP,    MUL_HL,    EDGE_APICAL);
            6'd28: c = mk(OP_NOP,    MUL_HH,    EDGE_APICAL);
            6'd30: c = mk(OP_SQSAVE, MUL_NONE,  EDGE_APICAL);
            6'd31: c = mk(OP_NOP,    MUL_S0,    EDGE_APICAL);
            6'd32: c = mk(OP_NOP,    MUL_S1,    EDGE_APICAL);
            6'd33: c = mk(OP_NOP,    MUL_S2,    EDGE_APICAL);
            6'd35: c = mk(OP_AADD,   MUL_NONE,  EDGE_APICAL);
            default: c = mk(OP_NOP,  MUL_NONE,  EDGE_APICAL);
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- src/vce_if.sv -----
// ============================================================================
// vce_if: stream channels of the vertex chain energy core
// Input channel carries one vertex pair per beat, output channel one energy.
// ============================================================================
`default_nettype none

interface vce_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [vce_pkg::COORD_W-1:0]  apex_x;
    logic signed [vce_pkg::COORD_W-1:0]  apex_y;
    logic signed [vce_pkg::COORD_W-1:0]  basal_x;
    logic signed [vce_pkg::COORD_W-1:0]  basal_y;
    logic                                last_pair;

    modport source (output valid, output apex_x, output apex_y, output basal_x,
                    output basal_y, output last_pair, input ready);
    modport sink   (input valid, input apex_x, input apex_y, input basal_x,
                    input basal_y, input last_pair, output ready);
endinterface

interface vce_out_if;
    logic                          valid;
    logic                          ready;
    logic [vce_pkg::ENERGY_W-1:0]  total_energy;
    logic                          saturated;

    modport source (output valid, output total_energy, output saturated, input ready);
    modport sink   (input valid, input total_energy, input saturated, output ready);
endinterface

`default_nettype wire

// ----- src/vertex_chain_energy_core.sv -----
// The energy is valid once a row's closing pair has passed the check, the
// 36 table steps with three root waits, the previous-pair load and the emit.
// One pair at a time: a pair closing a cell holds the input through the table
// walk, load and any emit; a row's first pair only through check, load and any emit.
// The result register lets the next pair in while an energy waits to be taken.
// Reset (rst_n, async low) restores register defaults and clears sums and state.
// ============================================================================
// vertex_chain_energy_core: energy of a row of quadrilateral cells
// Edge tension terms plus area stiffness term, summed per row, saturating.
// ============================================================================
`default_nettype none

module vertex_chain_energy_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    vce_in_if.sink                               in_ch,
    vce_out_if.source                            out_ch,
    input  wire logic                            cfg_we,
    input  wire logic [vce_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [vce_pkg::CFG_DATA_W-1:0]  cfg_data
);

    vce_pkg::cmd_t     cmd;
    vce_pkg::status_t  status;
    logic              in_ready;
    logic              in_accept;
    logic              out_take;

    assign in_ch.ready = in_ready;
    assign in_accept   = in_ch.valid & in_ready;
    assign out_take    = out_ch.valid & out_ch.ready;

    vce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    vce_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_accept (in_accept),
        .in_ax     (in_ch.apex_x),
        .in_ay     (in_ch.apex_y),
        .in_bx     (in_ch.basal_x),
        .in_by     (in_ch.basal_y),
        .in_last   (in_ch.last_pair),
        .out_take  (out_take),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_ch.valid),
        .out_total (out_ch.total_energy),
        .out_sat   (out_ch.saturated)
    );

    // one pair in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !in_ch.ready)
        else $error("pair accepted while previous pair still in work");

    // never overwrite a result that has not been taken
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !status.out_busy)
        else $error("result emitted over pending beat");

    // root start must not coincide with a multiply being issued
    a_root_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == vce_pkg::OP_ROOT) |-> (cmd.mul == vce_pkg::MUL_NONE))
        else $error("root start overlaps a multiply");

endmodule

`default_nettype wire

// ----- src/vce_isqrt.sv -----
// ============================================================================
// vce_isqrt: digit-by-digit integer square root
// Restoring method, one result bit per cycle, floor of the root.
// ============================================================================
`default_nettype none

module vce_isqrt (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [vce_pkg::RAD_W-1:0]     radicand,
    output logic                               done,
    output logic [vce_pkg::ROOT_W-1:0]         root
);

    localparam int CNT_W = $clog2(vce_pkg::ROOT_W + 1);

    logic [vce_pkg::RAD_W-1:0]  rad_reg,  rad_next;
    logic [vce_pkg::REM_W-1:0]  rem_reg,  rem_next;
    logic [vce_pkg::ROOT_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0]           cnt_reg,  cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;

    logic [vce_pkg::REM_W-1:0]  rem_sh;
    logic [vce_pkg::REM_W-1:0]  trial;

    // one digit per cycle
    always_comb
    begin
        rem_sh    = {rem_reg[vce_pkg::REM_W-3:0], rad_reg[vce_pkg::RAD_W-1 -: 2]};
        trial     = {{(vce_pkg::REM_W-vce_pkg::ROOT_W-2){1'b0}}, root_reg, 2'b01};
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(vce_pkg::ROOT_W);
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[vce_pkg::RAD_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[vce_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[vce_pkg::ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ----- src/vce_dpath.sv -----
// ============================================================================
// vce_dpath: datapath of the vertex chain energy core
// Config registers, vertex registers, shared multiplier, accumulator and sums.
// ============================================================================
`default_nettype none

module vce_dpath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [vce_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [vce_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              in_accept,
    input  wire logic [vce_pkg::COORD_W-1:0]       in_ax,
    input  wire logic [vce_pkg::COORD_W-1:0]       in_ay,
    input  wire logic [vce_pkg::COORD_W-1:0]       in_bx,
    input  wire logic [vce_pkg::COORD_W-1:0]       in_by,
    input  wire logic                              in_last,
    input  wire logic                              out_take,
    input  wire vce_pkg::cmd_t                     cmd,
    output vce_pkg::status_t                       status,
    output logic                                   out_valid,
    output logic [vce_pkg::ENERGY_W-1:0]           out_total,
    output logic                                   out_sat
);

    localparam int DW = vce_pkg::DIFF_W;
    localparam int EW = vce_pkg::ENERGY_W;
    localparam int AW = vce_pkg::ACC_W;

    // configuration
    logic [vce_pkg::TENS_W-1:0] ten_a_reg, ten_b_reg, ten_l_reg, stiff_reg;
    logic [vce_pkg::AREA_W-1:0] target_reg;

    // vertex registers
    logic [vce_pkg::COORD_W-1:0] pax_reg, pay_reg, pbx_reg, pby_reg;
    logic [vce_pkg::COORD_W-1:0] cax_reg, cay_reg, cbx_reg, cby_reg;
    logic                        last_reg;
    logic                        have_prev_reg, have_prev_next;

    // multiplier pipeline and accumulator
    logic [vce_pkg::PROD_W-1:0]  prod_reg;
    vce_pkg::mul_sel_t           psel_reg;
    logic                        psign_reg;
    logic signed [AW-1:0]        acc_reg, acc_next;
    logic [vce_pkg::MAG_W-1:0]   m_reg;
    logic [vce_pkg::SQ_W-1:0]    sq_reg;

    // sums
    logic [vce_pkg::ESUM3_W-1:0] esum3_reg, esum3_next;
    logic [EW-1:0]               esum_reg, esum_next;
    logic [EW-1:0]               asum_reg, asum_next;
    logic                        ovf_reg, ovf_next;
    logic                        out_valid_reg, out_valid_next;
    logic [EW-1:0]               out_total_reg;
    logic                        out_sat_reg;

    // root unit
    logic                        root_done;
    logic [vce_pkg::ROOT_W-1:0]  root;

    // combinational
    logic signed [DW-1:0]        dx, dy, ux, uy, vx, vy;
    logic [vce_pkg::OPND_W-1:0]  opa, opb;
    logic                        osign;
    logic [vce_pkg::TENS_W-1:0]  tension;
    logic [5:0]                  pshift;
    logic [AW-1:0]               pval;
    logic signed [AW-1:0]        sval;
    logic signed [AW-1:0]        acc_mag;
    logic [AW-27:0]              term_raw;
    logic [EW-1:0]               term;
    logic [EW:0]                 esum_add, asum_add, tot_add;

    function automatic logic signed [DW-1:0] sx(input logic [vce_pkg::COORD_W-1:0] v);
        return {v[vce_pkg::COORD_W-1], v};
    endfunction

    function automatic logic [vce_pkg::OPND_W-1:0] mag(input logic signed [DW-1:0] d);
        logic [DW-1:0] a;
        a = d[DW-1] ? DW'(-d) : DW'(d);
        return vce_pkg::OPND_W'(a);
    endfunction

    // edge and area differences
    always_comb
    begin
        unique case (cmd.edge_sel)
            vce_pkg::EDGE_APICAL:
            begin
                dx = sx(cax_reg) - sx(pax_reg);
                dy = sx(cay_reg) - sx(pay_reg);
                tension = ten_a_reg;
            end
            vce_pkg::EDGE_BASAL:
            begin
                dx = sx(cbx_reg) - sx(pbx_reg);
                dy = sx(cby_reg) - sx(pby_reg);
                tension = ten_b_reg;
            end
            default:
            begin
                dx = sx(pax_reg) - sx(pbx_reg);
                dy = sx(pay_reg) - sx(pby_reg);
                tension = ten_l_reg;
            end
        endcase
        ux = sx(cbx_reg) - sx(pax_reg);
        uy = sx(cby_reg) - sx(pay_reg);
        vx = sx(cax_reg) - sx(pbx_reg);
        vy = sx(cay_reg) - sx(pby_reg);
    end

    // multiplier operand select
    always_comb
    begin
        opa   = '0;
        opb   = '0;
        osign = 1'b0;
        unique case (cmd.mul)
            vce_pkg::MUL_DXDX:  begin opa = mag(dx); opb = mag(dx); end
            vce_pkg::MUL_DYDY:  begin opa = mag(dy); opb = mag(dy); end
            vce_pkg::MUL_TROOT:
            begin
                opa = vce_pkg::OPND_W'(tension);
                opb = root;
            end
            vce_pkg::MUL_UXVY:
            begin
                opa = mag(ux); opb = mag(vy);
                osign = ux[DW-1] ^ vy[DW-1];
            end
            vce_pkg::MUL_UYVX:
            begin
                opa = mag(uy); opb = mag(vx);
                osign = ~(uy[DW-1] ^ vx[DW-1]);
            end
            vce_pkg::MUL_LL:
            begin
                opa = vce_pkg::OPND_W'(m_reg[vce_pkg::HALF_W-1:0]);
                opb = vce_pkg::OPND_W'(m_reg[vce_pkg::HALF_W-1:0]);
            end
            vce_pkg::MUL_HL:
            begin
                opa = vce_pkg::OPND_W'(m_reg[vce_pkg::MAG_W-1:vce_pkg::HALF_W]);
                opb = vce_pkg::OPND_W'(m_reg[vce_pkg::HALF_W-1:0]);
            end
            vce_pkg::MUL_HH:
            begin
                opa = vce_pkg::OPND_W'(m_reg[vce_pkg::MAG_W-1:vce_pkg::HALF_W]);
                opb = vce_pkg::OPND_W'(m_reg[vce_pkg::MAG_W-1:vce_pkg::HALF_W]);
            end
            vce_pkg::MUL_S0:
            begin
                opa = vce_pkg::OPND_W'(stiff_reg);
                opb = vce_pkg::OPND_W'(sq_reg[vce_pkg::CHUNK_W-1:0]);
            end
            vce_pkg::MUL_S1:
            begin
                opa = vce_pkg::OPND_W'(stiff_reg);
                opb = vce_pkg::OPND_W'(sq_reg[2*vce_pkg::CHUNK_W-1:vce_pkg::CHUNK_W]);
            end
            vce_pkg::MUL_S2:
            begin
                opa = vce_pkg::OPND_W'(stiff_reg);
                opb = vce_pkg::OPND_W'(sq_reg[3*vce_pkg::CHUNK_W-1:2*vce_pkg::CHUNK_W]);
            end
            default: ;
        endcase
    end

    // accumulate stage: weight of each partial product
    always_comb
    begin
        unique case (psel_reg)
            vce_pkg::MUL_HL: pshift = 6'(vce_pkg::HALF_W + 1);
            vce_pkg::MUL_HH: pshift = 6'(2 * vce_pkg::HALF_W);
            vce_pkg::MUL_S1: pshift = 6'(vce_pkg::CHUNK_W);
            vce_pkg::MUL_S2: pshift = 6'(2 * vce_pkg::CHUNK_W);
            default:         pshift = 6'd0;
        endcase
        pval = AW'(prod_reg) << pshift;
        sval = psign_reg ? -$signed(pval) : $signed(pval);
    end

    // accumulator and scalar updates
    always_comb
    begin
        acc_next   = acc_reg;
        esum3_next = esum3_reg;
        esum_next  = esum_reg;
        asum_next  = asum_reg;
        ovf_next   = ovf_reg;
        have_prev_next = have_prev_reg;
        out_valid_next = out_valid_reg;
        acc_mag    = acc_reg[AW-1] ? -acc_reg : acc_reg;
        term_raw   = acc_reg[AW-1:26];
        term       = (|term_raw[AW-27:EW]) ? vce_pkg::MAX_ENERGY : term_raw[EW-1:0];
        esum_add   = {1'b0, esum_reg} + (EW+1)'(esum3_reg);
        asum_add   = {1'b0, asum_reg} + {1'b0, term};
        tot_add    = {1'b0, esum_reg} + {1'b0, asum_reg};

        unique case (psel_reg)
            vce_pkg::MUL_NONE: ;
            vce_pkg::MUL_DXDX, vce_pkg::MUL_TROOT, vce_pkg::MUL_UXVY,
            vce_pkg::MUL_LL, vce_pkg::MUL_S0:
                acc_next = sval;
            default:
                acc_next = acc_reg + sval;
        endcase

        unique case (cmd.op)
            vce_pkg::OP_TGT:
                acc_next = acc_reg - $signed(AW'({target_reg, 1'b0}));
            vce_pkg::OP_EADD:
                esum3_next = esum3_reg + acc_reg[vce_pkg::ESUM3_W+7:8];
            vce_pkg::OP_AADD:
            begin
                esum3_next = '0;
                if (esum_add[EW])
                begin
                    esum_next = vce_pkg::MAX_ENERGY;
                    ovf_next  = 1'b1;
                end
                else
                    esum_next = esum_add[EW-1:0];
                if (asum_add[EW])
                begin
                    asum_next = vce_pkg::MAX_ENERGY;
                    ovf_next  = 1'b1;
                end
                else
                    asum_next = asum_add[EW-1:0];
                if (|term_raw[AW-27:EW])
                    ovf_next = 1'b1;
            end
            vce_pkg::OP_LOADPREV:
                have_prev_next = 1'b1;
            default: ;
        endcase

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            esum_next      = '0;
            asum_next      = '0;
            ovf_next       = 1'b0;
            have_prev_next = 1'b0;
        end
        else if (out_take)
            out_valid_next = 1'b0;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ten_a_reg     <= 16'd256;
            ten_b_reg     <= 16'd256;
            ten_l_reg     <= 16'd256;
            stiff_reg     <= 16'd256;
            target_reg    <= 32'd65536;
            pax_reg       <= '0;
            pay_reg       <= '0;
            pbx_reg       <= '0;
            pby_reg       <= '0;
            have_prev_reg <= 1'b0;
            psel_reg      <= vce_pkg::MUL_NONE;
            esum3_reg     <= '0;
            esum_reg      <= '0;
            asum_reg      <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    vce_pkg::REG_APICAL_TENSION:  ten_a_reg  <= cfg_data[15:0];
                    vce_pkg::REG_BASAL_TENSION:   ten_b_reg  <= cfg_data[15:0];
                    vce_pkg::REG_LATERAL_TENSION: ten_l_reg  <= cfg_data[15:0];
                    vce_pkg::REG_AREA_STIFFNESS:  stiff_reg  <= cfg_data[15:0];
                    vce_pkg::REG_TARGET_AREA:     target_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.op == vce_pkg::OP_LOADPREV)
            begin
                pax_reg <= cax_reg;
                pay_reg <= cay_reg;
                pbx_reg <= cbx_reg;
                pby_reg <= cby_reg;
            end
            have_prev_reg <= have_prev_next;
            psel_reg      <= cmd.mul;
            esum3_reg     <= esum3_next;
            esum_reg      <= esum_next;
            asum_reg      <= asum_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cax_reg  <= in_ax;
            cay_reg  <= in_ay;
            cbx_reg  <= in_bx;
            cby_reg  <= in_by;
            last_reg <= in_last;
        end
        prod_reg  <= opa * opb;
        psign_reg <= osign;
        acc_reg   <= acc_next;
        if (cmd.op == vce_pkg::OP_ABS)
            m_reg <= acc_mag[vce_pkg::MAG_W-1:0];
        if (cmd.op == vce_pkg::OP_SQSAVE)
            sq_reg <= acc_reg[vce_pkg::SQ_W-1:0];
        if (cmd.emit)
        begin
            out_total_reg <= tot_add[EW] ? vce_pkg::MAX_ENERGY : tot_add[EW-1:0];
            out_sat_reg   <= ovf_reg | tot_add[EW];
        end
    end

    vce_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == vce_pkg::OP_ROOT),
        .radicand ({acc_reg[vce_pkg::RAD_W-17:0], 16'h0000}),
        .done     (root_done),
        .root     (root)
    );

    assign status.root_done = root_done;
    assign status.have_prev = have_prev_reg;
    assign status.last      = last_reg;
    assign status.out_busy  = out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_total = out_total_reg;
    assign out_sat   = out_sat_reg;

endmodule

`default_nettype wire

// ----- src/vce_ctrl.sv -----
// ============================================================================
// vce_ctrl: controller of the vertex chain energy core
// Walks the step table for each pair that has a previous pair, waits on the root unit, emits results.
// ============================================================================
`default_nettype none

module vce_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire vce_pkg::status_t  status,
    output vce_pkg::cmd_t          cmd
);

    vce_pkg::state_t              state_reg, state_next;
    logic [vce_pkg::STEP_W-1:0]   step_reg,  step_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        in_ready   = 1'b0;
        cmd        = vce_pkg::mk(vce_pkg::OP_NOP, vce_pkg::MUL_NONE, vce_pkg::EDGE_APICAL);
        unique case (state_reg)
            vce_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    state_next = vce_pkg::S_CHECK;
            end
            vce_pkg::S_CHECK:
            begin
                step_next  = '0;
                state_next = status.have_prev ? vce_pkg::S_RUN : vce_pkg::S_FIN;
            end
            vce_pkg::S_RUN:
            begin
                cmd       = vce_pkg::ucode(step_reg);
                step_next = step_reg + 1'b1;
                if (cmd.op == vce_pkg::OP_ROOT)
                    state_next = vce_pkg::S_ROOT;
                else if (step_reg == vce_pkg::STEP_W'(vce_pkg::LAST_STEP))
                    state_next = vce_pkg::S_FIN;
            end
            vce_pkg::S_ROOT:
            begin
                if (status.root_done)
                    state_next = vce_pkg::S_RUN;
            end
            vce_pkg::S_FIN:
            begin
                cmd = vce_pkg::mk(vce_pkg::OP_LOADPREV, vce_pkg::MUL_NONE,
                                  vce_pkg::EDGE_APICAL);
                state_next = status.last ? vce_pkg::S_EMIT : vce_pkg::S_IDLE;
            end
            vce_pkg::S_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = vce_pkg::S_IDLE;
                end
            end
            default: state_next = vce_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vce_pkg::S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

`default_nettype wire
